/* rtl/interval_partition_min_end_macros.svh */
// Assertion macros shared by the interval partition checker.
`ifndef INTERVAL_PARTITION_MIN_END_MACROS_SVH
`define INTERVAL_PARTITION_MIN_END_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IPME_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interval partition check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IPME_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("interval partition check failed");

`endif

/* rtl/ipme_pkg.sv */
// Types, constants and helpers for the interval partition block.
`timescale 1ns / 1ps
package ipme_pkg;

  localparam int unsigned MAX_STAGES = 16;
  localparam int unsigned IDX_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_STAGES + 1);
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STAGE_W    = 4;
  localparam int unsigned USE_W      = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DECIDE,
    ST_OUT
  } ipme_state_e;

  // read data strobe toward the minimum tracker
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } ipme_rd_t;

  // write port of the end time store
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [TIME_W-1:0] data;
  } ipme_wr_t;

  // stage index reported masked to the field width
  function automatic logic [STAGE_W-1:0] to_stage(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[STAGE_W-1:0];
  endfunction

  // stage count reported masked to the field width
  function automatic logic [USE_W-1:0] to_use(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[USE_W-1:0];
  endfunction

endpackage

/* rtl/ipme_mem.sv */
// Per-stage last end time store: one write port, one registered read port.
`timescale 1ns / 1ps
module ipme_mem
  import ipme_pkg::*;
(
  input  logic              clk_i,
  input  ipme_wr_t          wr_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output logic [TIME_W-1:0] rd_data_o
);

  logic [TIME_W-1:0] mem_q [MAX_STAGES];
  logic [TIME_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/ipme_min.sv */
// Shared compare unit: tracks the smallest end time seen during a scan.
`timescale 1ns / 1ps
module ipme_min
  import ipme_pkg::*;
(
  input  logic              clk_i,
  input  ipme_rd_t          rd_i,
  input  logic [TIME_W-1:0] data_i,
  output logic [TIME_W-1:0] best_val_o,
  output logic [IDX_W-1:0]  best_idx_o
);

  logic [TIME_W-1:0] best_val_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              take;

  // stage 0 seeds the scan; strict less keeps the lowest stage on a tie
  assign take = rd_i.vld && ((rd_i.idx == '0) || (data_i < best_val_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_val_q <= data_i;
      best_idx_q <= rd_i.idx;
    end
  end

  assign best_val_o = best_val_q;
  assign best_idx_o = best_idx_q;

endmodule

/* rtl/ipme_ctrl.sv */
// Sequencer: scans open stages, decides placement, holds the result word.
`timescale 1ns / 1ps
module ipme_ctrl
  import ipme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               first_of_batch_i,
  input  logic [TIME_W-1:0]  start_time_i,
  input  logic [TIME_W-1:0]  end_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [STAGE_W-1:0] stage_o,
  output logic               opened_new_o,
  output logic               overflow_o,
  output logic [USE_W-1:0]   stages_in_use_o,
  output logic               rd_en_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  output ipme_rd_t           rd_o,
  output ipme_wr_t           wr_o,
  input  logic [TIME_W-1:0]  best_val_i,
  input  logic [IDX_W-1:0]   best_idx_i
);

  ipme_state_e state_q, state_d;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   scan_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [TIME_W-1:0]  start_q, end_q;
  logic [STAGE_W-1:0] stage_q;
  logic               opened_q, over_q;
  logic [USE_W-1:0]   use_q;

  logic               accept;
  logic               scan_last;
  logic               fits;
  logic               full;
  logic               load_res;
  logic [STAGE_W-1:0] stage_d;
  logic               opened_d, over_d;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == cnt_q);
  assign fits      = (cnt_q != '0) && (start_q > best_val_i);
  assign full      = (cnt_q == CNT_W'(MAX_STAGES));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (first_of_batch_i || (cnt_q == '0)) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_WAIT;
      end
      ST_WAIT:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    wr_o       = '{en: 1'b0, addr: '0, data: end_q};
    cnt_d      = cnt_q;
    load_res   = 1'b0;
    stage_d    = '0;
    opened_d   = 1'b0;
    over_d     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept && first_of_batch_i) cnt_d = '0;
      end
      ST_SCAN: rd_en_o = 1'b1;
      ST_DECIDE: begin
        load_res = 1'b1;
        if (fits) begin
          wr_o.en   = 1'b1;
          wr_o.addr = best_idx_i;
          stage_d   = to_stage(best_idx_i);
        end else if (!full) begin
          wr_o.en   = 1'b1;
          wr_o.addr = cnt_q[IDX_W-1:0];
          stage_d   = to_stage(cnt_q[IDX_W-1:0]);
          opened_d  = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
        end else begin
          over_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_en_o;
    end
  end

  // payload: latched interval, scan index, result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q <= start_time_i;
      end_q   <= end_time_i;
      scan_q  <= '0;
    end else if (rd_en_o) begin
      scan_q  <= scan_q + IDX_W'(1);
    end
    rd_idx_q <= scan_q;
    if (load_res) begin
      stage_q  <= stage_d;
      opened_q <= opened_d;
      over_q   <= over_d;
      use_q    <= to_use(cnt_d);
    end
  end

  assign rd_addr_o       = scan_q;
  assign rd_o            = '{vld: rd_vld_q, idx: rd_idx_q};
  assign out_valid_o     = (state_q == ST_OUT);
  assign stage_o         = stage_q;
  assign opened_new_o    = opened_q;
  assign overflow_o      = over_q;
  assign stages_in_use_o = use_q;

endmodule

/* rtl/interval_partition_min_end.sv */
// Interval partitioning onto stages with a minimum last-end-time choice.
//
// Input channel (in_valid_i / in_ready_o) takes one word per interval:
// first_of_batch_i, start_time_i, end_time_i, sorted by start then end.
// first_of_batch_i closes all open stages before the interval is placed.
// Output channel (out_valid_o / out_ready_i) gives one word per interval:
// stage_o, opened_new_o, overflow_o, stages_in_use_o.
//
// With N stages open, an accepted word goes through ST_SCAN, which reads the
// N stored end times, then ST_WAIT, ST_DECIDE and ST_OUT, where out_valid_o
// is raised; ST_SCAN and ST_WAIT are skipped when no stage is open or
// first_of_batch_i is set. The scan reads one stored end time per cycle
// through the store's read port into one shared compare unit; the next word
// is taken only after the result word has been delivered.
// Reset clears the open stage count and the sequencer; stored end times are
// not cleared, as only stages opened since the last clear are read.
// While out_ready_i is low the result word is held and in_ready_o stays low.
`timescale 1ns / 1ps
module interval_partition_min_end
  import ipme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               first_of_batch_i,
  input  logic [TIME_W-1:0]  start_time_i,
  input  logic [TIME_W-1:0]  end_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [STAGE_W-1:0] stage_o,
  output logic               opened_new_o,
  output logic               overflow_o,
  output logic [USE_W-1:0]   stages_in_use_o
);

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] rd_data;
  ipme_rd_t          rd;
  ipme_wr_t          wr;
  logic [TIME_W-1:0] best_val;
  logic [IDX_W-1:0]  best_idx;

  // sequencer
  ipme_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_of_batch_i (first_of_batch_i),
    .start_time_i     (start_time_i),
    .end_time_i       (end_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .stage_o          (stage_o),
    .opened_new_o     (opened_new_o),
    .overflow_o       (overflow_o),
    .stages_in_use_o  (stages_in_use_o),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_o             (rd),
    .wr_o             (wr),
    .best_val_i       (best_val),
    .best_idx_i       (best_idx)
  );

  // end time store
  ipme_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // shared compare unit
  ipme_min u_min (
    .clk_i      (clk_i),
    .rd_i       (rd),
    .data_i     (rd_data),
    .best_val_o (best_val),
    .best_idx_o (best_idx)
  );

endmodule

/* rtl/ipme_checker.sv */
// Port-level checks for the interval partition block, bound to the top level.
`timescale 1ns / 1ps
`include "interval_partition_min_end_macros.svh"
module ipme_checker
  import ipme_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [STAGE_W-1:0] stage_o,
  input logic               opened_new_o,
  input logic               overflow_o,
  input logic [USE_W-1:0]   stages_in_use_o
);

  // a stalled result word holds
  `IPME_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(stage_o) && $stable(stages_in_use_o))

  // one word in flight: busy right after an accept
  `IPME_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // no new word taken while a result waits
  `IPME_ASSERT_IMP(a_no_accept_pending, out_valid_o, !in_ready_o)

  // overflow only when every stage is open, and nothing assigned
  `IPME_ASSERT_IMP(a_overflow_full, out_valid_o && overflow_o, !opened_new_o && (stage_o == '0) && (stages_in_use_o == USE_W'(MAX_STAGES)))

  // a newly opened stage is the last one counted
  `IPME_ASSERT_IMP(a_open_is_last, out_valid_o && opened_new_o, stages_in_use_o == (USE_W'(stage_o) + USE_W'(1)))

endmodule

bind interval_partition_min_end ipme_checker u_ipme_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .stage_o         (stage_o),
  .opened_new_o    (opened_new_o),
  .overflow_o      (overflow_o),
  .stages_in_use_o (stages_in_use_o)
);

/* dv/ipme_stage_check.sv */
// Stage assignment monitor: predicts each placement and compares result words.
`timescale 1ns / 1ps
module ipme_stage_check
  import ipme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               first_of_batch_i,
  input  logic [TIME_W-1:0]  start_time_i,
  input  logic [TIME_W-1:0]  end_time_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [STAGE_W-1:0] stage_i,
  input  logic               opened_new_i,
  input  logic               overflow_i,
  input  logic [USE_W-1:0]   stages_in_use_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 overflow_count_o,
  output int                 opened_count_o
);

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic               opened_new;
    logic               overflow;
    logic [USE_W-1:0]   in_use;
  } placement_t;

  // predictor state: last end time per stage and the open stage count
  logic [TIME_W-1:0] last_end [MAX_STAGES];
  int unsigned       open_stages = 0;

  placement_t expected_placements [$];
  placement_t want;
  placement_t got;
  int fail_count     = 0;
  int pending        = 0;
  int checked        = 0;
  int overflow_count = 0;
  int opened_count   = 0;

  assign fail_count_o     = fail_count;
  assign pending_o        = pending;
  assign checked_o        = checked;
  assign overflow_count_o = overflow_count;
  assign opened_count_o   = opened_count;

  initial begin
    for (int i = 0; i < MAX_STAGES; i++) last_end[i] = '0;
  end

  // one line per mismatch, printing capped to keep the log short
  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // greedy placement: reuse the stage that frees up first, else open one
  task automatic place_interval(input logic first, input logic [TIME_W-1:0] s,
                                input logic [TIME_W-1:0] e, output placement_t p);
    int unsigned best;
    int unsigned stage;
    bit          fits;
    best  = 0;
    stage = 0;
    fits  = 1'b0;
    p     = '0;
    if (first) open_stages = 0;
    if (open_stages > 0) begin
      for (int unsigned i = 1; i < open_stages; i++) begin
        if (last_end[i] < last_end[best]) best = i;
      end
      // start must be strictly past the stage's end time
      if (s > last_end[best]) begin
        last_end[best] = e;
        stage = best;
        fits  = 1'b1;
      end
    end
    if (!fits) begin
      if (open_stages < MAX_STAGES) begin
        stage = open_stages;
        last_end[open_stages] = e;
        open_stages++;
        p.opened_new = 1'b1;
      end else begin
        // all stages busy: nothing placed, state untouched
        p.overflow = 1'b1;
        stage = 0;
      end
    end
    p.stage  = stage[STAGE_W-1:0];
    p.in_use = open_stages[USE_W-1:0];
  endtask

  // result side first: a word leaving now belongs to an earlier interval
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending == 0) begin
          report_mismatch($sformatf("result word with no interval outstanding (stage %0d)",
                                    stage_i));
        end else begin
          want = expected_placements.pop_front();
          pending--;
          checked++;
          if (stage_i !== want.stage)
            report_mismatch($sformatf("stage: got %0d, expected %0d", stage_i, want.stage));
          if (opened_new_i !== want.opened_new)
            report_mismatch($sformatf("opened_new: got %0b, expected %0b",
                                      opened_new_i, want.opened_new));
          if (overflow_i !== want.overflow)
            report_mismatch($sformatf("overflow: got %0b, expected %0b",
                                      overflow_i, want.overflow));
          if (stages_in_use_i !== want.in_use)
            report_mismatch($sformatf("stages_in_use: got %0d, expected %0d",
                                      stages_in_use_i, want.in_use));
        end
      end
      if (in_valid_i && in_ready_i) begin
        place_interval(first_of_batch_i, start_time_i, end_time_i, got);
        expected_placements = {expected_placements, got};
        pending++;
        if (got.overflow) overflow_count++;
        if (got.opened_new) opened_count++;
      end
    end
  end

endmodule

/* dv/tb_interval_partition_min_end.sv */
// Testbench top: clock, reset, interval stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_interval_partition_min_end;
  import ipme_pkg::*;

  localparam int NUM_INTERVALS = 1500;

  logic               clk;
  logic               rst_n;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               first_of_batch = 1'b0;
  logic [TIME_W-1:0]  start_time     = '0;
  logic [TIME_W-1:0]  end_time       = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [STAGE_W-1:0] stage;
  logic               opened_new;
  logic               overflow;
  logic [USE_W-1:0]   stages_in_use;

  int fail_count;
  int pending;
  int checked;
  int overflow_count;
  int opened_count;

  int intervals_sent = 0;
  int batches_sent   = 0;
  int burst_left     = 0;
  bit drained_once   = 1'b0;

  interval_partition_min_end uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .first_of_batch_i (first_of_batch),
    .start_time_i     (start_time),
    .end_time_i       (end_time),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .stage_o          (stage),
    .opened_new_o     (opened_new),
    .overflow_o       (overflow),
    .stages_in_use_o  (stages_in_use)
  );

  ipme_stage_check stage_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .first_of_batch_i (first_of_batch),
    .start_time_i     (start_time),
    .end_time_i       (end_time),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .stage_i          (stage),
    .opened_new_i     (opened_new),
    .overflow_i       (overflow),
    .stages_in_use_i  (stages_in_use),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .overflow_count_o (overflow_count),
    .opened_count_o   (opened_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog: slowest run is ~1600 words
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [63:0] b);
    logic [63:0] sum;
    sum = {32'd0, a} + b;
    return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // offer one interval word; returns on the falling edge after it is taken
  task automatic offer_interval(input logic first, input logic [TIME_W-1:0] s,
                                input logic [TIME_W-1:0] e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    first_of_batch <= first;
    start_time     <= s;
    end_time       <= e;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    intervals_sent++;
  endtask

  // sorted batch: starts nondecreasing, ties ordered by end time
  task automatic send_batch(input bit clear);
    int          n;
    int          overlap;
    logic [31:0] scale;
    logic [31:0] t;
    logic [31:0] e;
    logic [31:0] prev_t;
    logic [31:0] prev_e;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
    case ($urandom_range(0, 4))
      0: scale = 1;
      1: scale = 8;
      2: scale = 1000;
      3: scale = 32'h0010_0000;
      default: scale = 32'h0400_0000;
    endcase
    // long durations relative to the start spacing pile up many stages
    overlap = $urandom_range(1, 24);
    t = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100);
    prev_t = t;
    prev_e = '0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) t = sat_add(t, 64'($urandom_range(0, scale)));
      e = sat_add(t, 64'($urandom_range(0, scale)) * overlap);
      if (k > 0 && t == prev_t && e < prev_e) e = prev_e;
      offer_interval(clear && k == 0, t, e);
      prev_t = t;
      prev_e = e;
    end
    batches_sent++;
  endtask

  // unsorted words with random fields, the odd clear among them
  task automatic send_noise();
    int          n;
    logic [31:0] s;
    logic [31:0] e;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      s = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 16);
      e = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 16);
      offer_interval($urandom_range(0, 7) == 0, s, e);
    end
    batches_sent++;
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int mode;
    int span;
    bit held;
    mode = 0;
    span = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && checked >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 80);
      end
      span--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // reset, directed words, random batches, drain and verdict
  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // no stage open yet, equal start and end, tie, start after end
    offer_interval(1'b0, 32'd0, 32'd0);
    offer_interval(1'b0, 32'd0, 32'd7);
    offer_interval(1'b0, 32'd1, 32'd9);
    offer_interval(1'b0, 32'd8, 32'd9);
    offer_interval(1'b0, 32'd10, 32'hFFFF_FFFF);
    offer_interval(1'b0, 32'hFFFF_FFFF, 32'd0);
    // fill every stage, then overflow twice
    for (int k = 0; k < MAX_STAGES; k++) begin
      offer_interval(k == 0, 32'h8000_0000, 32'hFFFF_FFFF);
    end
    offer_interval(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_interval(1'b0, 32'hFFFF_FFFF, 32'd0);
    batches_sent = 2;

    while (intervals_sent < NUM_INTERVALS) begin
      if (!drained_once && intervals_sent >= 700) begin
        drained_once = 1'b1;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        burst_left = 0;
      end
      case ($urandom_range(0, 9))
        0: send_noise();
        1: send_batch(1'b0);
        default: send_batch(1'b1);
      endcase
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d intervals in %0d batches (directed, sorted, unsorted); %0d checked.",
             intervals_sent, batches_sent, checked);
    $display("Stages opened: %0d, overflow results: %0d.", opened_count, overflow_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
